>>> src/polyphonic_sample_player_defines.svh
`ifndef POLYPHONIC_SAMPLE_PLAYER_DEFINES_SVH
`define POLYPHONIC_SAMPLE_PLAYER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psp_pkg.sv
`default_nettype none

package psp_pkg;

  localparam int VOICES_DEF      = 16;
  localparam int STORE_DEPTH_DEF = 65536;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2,
    KIND_TICK     = 2'd3
  } kind_e;

  localparam logic CFG_SAMPLE_LENGTH = 1'b0;
  localparam logic CFG_RATE_RATIO    = 1'b1;

  localparam logic [15:0] SAMPLE_LENGTH_RST = 16'd0;
  localparam logic [17:0] RATE_RATIO_RST    = 18'd65536;

  // 0.30 in q0.16
  localparam logic [15:0] SCALE_Q16 = 16'd19661;

  // round(2^(k/12) * 65536)
  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic [6:0]  note;
    logic [31:0] pos;
    logic [23:0] step;
  } voice_t;

  typedef struct packed {
    logic accept;
    logic step_mul;
    logic step_shift;
    logic sweep_rd;
    logic scale;
    logic emit;
  } psp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } psp_sts_t;

  function automatic logic [3:0] note_octave(input logic [6:0] note);
    logic [3:0] oct;
    oct = 4'd0;
    for (int i = 1; i <= 10; i++) begin
      if (note >= 7'(12 * i)) oct = oct + 4'd1;
    end
    return oct;
  endfunction

  function automatic logic [3:0] note_semitone(input logic [6:0] note);
    logic [6:0] base;
    base = {3'b0, note_octave(note)} * 7'd12;
    return 4'(note - base);
  endfunction

endpackage

`default_nettype wire

>>> src/psp_ram.sv
`default_nettype none

module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/psp_ctrl.sv
`default_nettype none

`include "polyphonic_sample_player_defines.svh"

module psp_ctrl
  import psp_pkg::*;
#(
  parameter int VOICES = VOICES_DEF,
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_kind_i,
  output logic               in_ready_o,
  output psp_cmd_t           cmd_o,
  output logic     [VW-1:0]  voice_idx_o,
  input  wire psp_sts_t      sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SHIFT,
    S_NSWEEP,
    S_NDRAIN,
    S_TSWEEP,
    S_TDRAIN1,
    S_TDRAIN2,
    S_SCALE,
    S_EMIT
  } state_e;

  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  state_e          state_q;
  logic   [VW-1:0] cnt_q;
  logic            accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign voice_idx_o = cnt_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.step_mul   = (state_q == S_MUL);
    cmd_o.step_shift = (state_q == S_SHIFT);
    cmd_o.sweep_rd   = (state_q == S_NSWEEP) || (state_q == S_TSWEEP);
    cmd_o.scale      = (state_q == S_SCALE);
    cmd_o.emit       = (state_q == S_EMIT) && !sts_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            case (kind_e'(in_kind_i))
              KIND_NOTE_ON:  state_q <= S_MUL;
              KIND_NOTE_OFF: state_q <= S_NSWEEP;
              KIND_TICK:     state_q <= S_TSWEEP;
              default:       state_q <= S_IDLE;
            endcase
          end
        end
        S_MUL:   state_q <= S_SHIFT;
        S_SHIFT: state_q <= S_NSWEEP;
        S_NSWEEP: begin
          if (cnt_q == LAST_VOICE) state_q <= S_NDRAIN;
          else cnt_q <= cnt_q + VW'(1);
        end
        S_NDRAIN: state_q <= S_IDLE;
        S_TSWEEP: begin
          if (cnt_q == LAST_VOICE) state_q <= S_TDRAIN1;
          else cnt_q <= cnt_q + VW'(1);
        end
        S_TDRAIN1: state_q <= S_TDRAIN2;
        S_TDRAIN2: state_q <= S_SCALE;
        S_SCALE:   state_q <= S_EMIT;
        S_EMIT: begin
          if (!sts_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PSP_ASSERT_NXT(a_tick_starts_sweep, accept && (in_kind_i == KIND_TICK), (state_q == S_TSWEEP) && (cnt_q == '0), "tick did not start a voice walk at voice 0")
  `PSP_ASSERT_IMP(a_shift_after_mul, state_q == S_SHIFT, $past(state_q) == S_MUL, "step shift without a preceding multiply")
  `PSP_ASSERT_NXT(a_drain_to_scale, state_q == S_TDRAIN2, state_q == S_SCALE, "tick drain did not reach scaling")

endmodule

`default_nettype wire

>>> src/psp_datapath.sv
`default_nettype none

`include "polyphonic_sample_player_defines.svh"

module psp_datapath
  import psp_pkg::*;
#(
  parameter int VOICES      = VOICES_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic        [1:0]  kind_i,
  input  wire logic        [6:0]  note_i,
  input  wire logic        [15:0] sample_index_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [17:0] cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [15:0] audio_out_o,
  input  wire psp_cmd_t           cmd_i,
  input  wire logic      [VW-1:0] voice_idx_i,
  output psp_sts_t                sts_o
);

  localparam int SW = 16 + $clog2(VOICES);
  localparam int PW = SW + 16;
  localparam int VBITS = $bits(voice_t);
  localparam logic signed [PW-16:0] SAT_HI = (PW - 15)'(32767);
  localparam logic signed [PW-16:0] SAT_LO = -(PW - 15)'(32768);

  // configuration
  logic [15:0] sample_length_q;
  logic [17:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_length_q <= SAMPLE_LENGTH_RST;
      rate_q          <= RATE_RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_LENGTH: sample_length_q <= cfg_data_i[15:0];
        CFG_RATE_RATIO:    rate_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  kind_e      kind_q;
  logic [6:0] note_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_e'(kind_i);
      note_q <= note_i;
    end
  end

  // step: rate * semitone, then octave shift
  logic [34:0] sprod_q;
  logic [3:0]  oct_q;
  logic [23:0] step_q;
  logic [4:0]  shamt;

  assign shamt = 5'd21 - {1'b0, oct_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul) begin
      sprod_q <= 35'(rate_q) * 35'(SEMITONE_Q16[note_semitone(note_q)]);
      oct_q   <= note_octave(note_q);
    end
    // shift is at least 11, so the result always fits in 24 bits
    if (cmd_i.step_shift) step_q <= 24'(sprod_q >> shamt);
  end

  // sample store
  logic          smp_we;
  logic          smp_re;
  logic [AW-1:0] smp_raddr;
  logic [15:0]   smp_rdata;

  assign smp_we = cmd_i.accept && (kind_i == KIND_LOAD) &&
                  ({16'b0, sample_index_i} < 32'(STORE_DEPTH));

  psp_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (smp_we),
    .waddr_i(AW'(sample_index_i)),
    .wdata_i(sample_value_i),
    .re_i   (smp_re),
    .raddr_i(smp_raddr),
    .rdata_o(smp_rdata)
  );

  // voice state
  logic [VOICES-1:0] voice_valid_q, voice_valid_d;
  logic              v_we;
  voice_t            v_wdata;
  logic [VBITS-1:0]  v_rdata;

  logic          p1_valid_q;
  logic          p1_vld_q;
  logic [VW-1:0] p1_voice_q;
  logic          found_q, found_d;
  logic          p2_hit_q, hit_d;

  psp_ram #(
    .WIDTH(VBITS),
    .DEPTH(VOICES)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(p1_voice_q),
    .wdata_i(v_wdata),
    .re_i   (cmd_i.sweep_rd),
    .raddr_i(voice_idx_i),
    .rdata_o(v_rdata)
  );

  voice_t      rd;
  logic [6:0]  note_eff;
  logic [15:0] ipos;
  logic [32:0] np;
  logic [32:0] pos_end;

  always_comb begin
    rd            = voice_t'(v_rdata);
    note_eff      = p1_vld_q ? rd.note : 7'd0;
    ipos          = rd.pos[31:16];
    np            = {1'b0, rd.pos} + 33'(rd.step);
    pos_end       = {1'b0, sample_length_q, 16'b0};
    v_we          = 1'b0;
    v_wdata       = rd;
    voice_valid_d = voice_valid_q;
    found_d       = found_q;
    smp_re        = 1'b0;
    smp_raddr     = AW'(ipos);
    hit_d         = 1'b0;
    case (kind_q)
      KIND_NOTE_ON: begin
        if (p1_valid_q && !found_q && (note_eff == 7'd0)) begin
          v_we                      = 1'b1;
          v_wdata.note              = note_q;
          v_wdata.pos               = '0;
          v_wdata.step              = step_q;
          voice_valid_d[p1_voice_q] = 1'b1;
          found_d                   = 1'b1;
        end
      end
      KIND_NOTE_OFF: begin
        // a voice without its valid bit reads as note zero
        if (p1_valid_q && !found_q && (note_eff == note_q)) begin
          voice_valid_d[p1_voice_q] = 1'b0;
          found_d                   = 1'b1;
        end
      end
      KIND_TICK: begin
        if (p1_valid_q && (note_eff != 7'd0)) begin
          smp_re = 1'b1;
          hit_d  = (ipos < sample_length_q) && ({16'b0, ipos} < 32'(STORE_DEPTH));
          v_we   = 1'b1;
          // past the end: park at the end and stop
          if (np > pos_end) begin
            v_wdata.pos  = pos_end[31:0];
            v_wdata.step = '0;
          end else begin
            v_wdata.pos = np[31:0];
          end
        end
      end
      default: ;
    endcase
    if (cmd_i.accept) found_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_valid_q <= '0;
      p1_valid_q    <= 1'b0;
      p1_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      p2_hit_q      <= 1'b0;
    end else begin
      voice_valid_q <= voice_valid_d;
      p1_valid_q    <= cmd_i.sweep_rd;
      p1_vld_q      <= voice_valid_q[voice_idx_i];
      found_q       <= found_d;
      p2_hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_voice_q <= voice_idx_i;
  end

  // mix, scale, round, saturate
  logic signed [SW-1:0]  sum_q;
  logic signed [PW-1:0]  mprod_q;
  logic signed [PW:0]    rnd_full;
  logic signed [PW-16:0] rnd;
  logic signed [15:0]    sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sum_q <= '0;
    else if (p2_hit_q) sum_q <= sum_q + SW'($signed(smp_rdata));
    if (cmd_i.scale) begin
      mprod_q <= $signed({{16{sum_q[SW-1]}}, sum_q}) * $signed(PW'(SCALE_Q16));
    end
  end

  always_comb begin
    // round half up, then floor by arithmetic shift
    rnd_full = {mprod_q[PW-1], mprod_q} + (PW + 1)'(32768);
    rnd      = rnd_full[PW:16];
    if (rnd > SAT_HI) sat = 16'sh7fff;
    else if (rnd < SAT_LO) sat = -16'sh8000;
    else sat = 16'(rnd);
  end

  logic               out_valid_q;
  logic signed [15:0] audio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) audio_q <= sat;
  end

  assign out_valid_o     = out_valid_q;
  assign audio_out_o     = audio_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  `PSP_ASSERT_IMP(a_found_only_notes, $rose(found_q), (kind_q == KIND_NOTE_ON) || (kind_q == KIND_NOTE_OFF), "voice match flagged outside a note transaction")
  `PSP_ASSERT_NXT(a_emit_shows, cmd_i.emit, out_valid_q, "emitted sample not presented")
  `PSP_ASSERT_IMP(a_hit_from_walk, p2_hit_q, $past(p1_valid_q) && (kind_q == KIND_TICK), "sample accumulate without a voice read")

endmodule

`default_nettype wire

>>> src/polyphonic_sample_player.sv
`default_nettype none

// Polyphonic sample player: plays one mono sample, held in an on-chip store, at up to VOICES
// pitches at once. Items come in on a valid/ready channel: a load writes one sample word; a
// note-off walks the voice table; a note-on computes its step (one multiply, one shift) and
// then walks the table; an output tick walks the table and yields one mixed, scaled (x0.30)
// and saturated sample. The walk reads one voice per cycle from the voice state memory, so
// VOICES sets the item time. The output sits in a register, so the next item is taken while
// a sample waits; a second tick holds in its emit state until the pending sample is taken.
// No clearing pass after reset.

module polyphonic_sample_player
  import psp_pkg::*;
#(
  parameter int VOICES      = VOICES_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [1:0]  kind_i,
  input  wire logic        [6:0]  note_i,
  input  wire logic        [15:0] sample_index_i,
  input  wire logic signed [15:0] sample_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [15:0] audio_out_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [17:0] cfg_data_i
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  psp_cmd_t      cmd;
  psp_sts_t      sts;
  logic [VW-1:0] voice_idx;

  psp_ctrl #(
    .VOICES(VOICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (kind_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .voice_idx_o(voice_idx),
    .sts_i      (sts)
  );

  psp_datapath #(
    .VOICES     (VOICES),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .note_i        (note_i),
    .sample_index_i(sample_index_i),
    .sample_value_i(sample_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .audio_out_o   (audio_out_o),
    .cmd_i         (cmd),
    .voice_idx_i   (voice_idx),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import psp_pkg::*;

  localparam int VOICES        = VOICES_DEF;
  localparam int STORE_WORDS   = 65536;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  localparam int PRESS_NONE  = 0;
  localparam int PRESS_HOLD  = 1;
  localparam int PRESS_PAUSE = 2;

  // 2^(k/12) in q16, k = 0..11
  localparam int SEMI_STEP [12] = '{
    65536, 69433, 73562, 77936, 82570, 87480,
    92682, 98193, 104032, 110218, 116772, 123715
  };

  typedef struct {
    bit                 is_reg;
    logic               reg_sel;
    kind_e              kind;
    logic [6:0]         note;
    logic [15:0]        addr;
    logic [17:0]        data;   // register value, or sample word in the low half
    bit                 fixed;
    logic signed [15:0] audio;
  } stim_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i         = '0;
  logic [6:0]         note_i         = '0;
  logic [15:0]        sample_index_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic signed [15:0] audio_out_o;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_idx_i      = 1'b0;
  logic [17:0]        cfg_data_i     = '0;

  // voice bank mirror
  logic [6:0]         pv_note [VOICES];
  logic [31:0]        pv_pos [VOICES];
  logic [23:0]        pv_step [VOICES];
  logic signed [15:0] pv_store [STORE_WORDS];
  bit                 pv_written [STORE_WORDS];
  logic [15:0]        pv_len  = 16'd0;
  logic [17:0]        pv_rate = 18'd65536;

  logic signed [15:0] audio_expected_q [$];
  stim_row_t          rows [$];
  int                 mismatch_cnt = 0;
  bit                 quiet        = 1'b0;
  bit                 hold_req     = 1'b0;

  polyphonic_sample_player u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .note_i         (note_i),
    .sample_index_i (sample_index_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .audio_out_o    (audio_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [23:0] note_step(input logic [6:0] n);
    longint unsigned prod;
    int oct;
    oct  = int'(n) / 12;
    prod = 64'(pv_rate) * 64'(SEMI_STEP[int'(n) % 12]);
    prod = prod >> (21 - oct);
    if (prod > 64'hFF_FFFF) return 24'hFF_FFFF;
    return prod[23:0];
  endfunction

  // applies one transaction to the mirror; returns 1 when a sample comes out
  function automatic bit apply_item(input kind_e k, input logic [6:0] n,
                                    input logic [15:0] a, input logic signed [15:0] w,
                                    output logic signed [15:0] audio);
    longint      sum;
    longint      r;
    logic [63:0] np;
    logic [63:0] stop;
    logic [15:0] ipos;
    audio = '0;
    case (k)
      KIND_LOAD: begin
        pv_store[a]   = w;
        pv_written[a] = 1'b1;
        return 1'b0;
      end
      KIND_NOTE_ON: begin
        for (int v = 0; v < VOICES; v++) begin
          if (pv_note[v] == 7'd0) begin
            pv_pos[v]  = '0;
            pv_step[v] = note_step(n);
            pv_note[v] = n;
            break;
          end
        end
        return 1'b0;
      end
      KIND_NOTE_OFF: begin
        for (int v = 0; v < VOICES; v++) begin
          if (pv_note[v] == n) begin
            pv_pos[v]  = '0;
            pv_step[v] = '0;
            pv_note[v] = '0;
            break;
          end
        end
        return 1'b0;
      end
      default: begin
        sum  = 0;
        stop = {32'b0, pv_len, 16'b0};
        for (int v = 0; v < VOICES; v++) begin
          if (pv_note[v] != 7'd0) begin
            ipos = pv_pos[v][31:16];
            if (ipos < pv_len) sum += pv_store[ipos];
            np = {32'b0, pv_pos[v]} + {40'b0, pv_step[v]};
            // past the end: park on the last frame boundary and stop moving
            if (np > stop) begin
              np         = stop;
              pv_step[v] = '0;
            end
            pv_pos[v] = np[31:0];
          end
        end
        r = (sum * 19661 + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        audio = r[15:0];
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_item(input kind_e k, input logic [6:0] n, input logic [15:0] a,
                           input logic signed [15:0] w, input bit fixed = 1'b0,
                           input logic signed [15:0] fixed_audio = '0);
    logic signed [15:0] audio;
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    note_i         <= n;
    sample_index_i <= a;
    sample_value_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (apply_item(k, n, a, w, audio))
      audio_expected_q.push_back(fixed ? fixed_audio : audio);
  endtask

  task automatic wait_drained(input bit settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (audio_expected_q.size() != 0) @(posedge clk_i);
    // loads and note events leave no sample behind, so give the walk time to finish
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [17:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_SAMPLE_LENGTH) pv_len = data[15:0];
    else pv_rate = data;
  endtask

  task automatic run_phase(input logic [15:0] len, input logic [17:0] rate,
                           input int count, input int pressure);
    kind_e              k;
    logic [6:0]         n;
    logic [15:0]        a;
    logic signed [15:0] w;
    int                 v;
    int                 pick;
    wait_drained(1'b1);
    write_reg(CFG_SAMPLE_LENGTH, {2'b0, len});
    write_reg(CFG_RATE_RATIO, rate);
    for (int i = 0; i < count; i++) begin
      if (pressure == PRESS_HOLD && i == count / 3) hold_req = 1'b1;
      if (pressure == PRESS_PAUSE && i == count / 2) wait_drained(1'b0);
      n    = 7'($urandom);
      a    = 16'($urandom);
      w    = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        k = KIND_LOAD;
        if ($urandom_range(0, 3) != 0 && pv_len != 0) a = 16'($urandom_range(0, pv_len - 1));
        if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end else if (pick < 42) begin
        k = KIND_NOTE_ON;
        case ($urandom_range(0, 9))
          0: n = 7'($urandom_range(0, 127));
          1: n = $urandom_range(0, 1) ? 7'd127 : 7'd0;
          default: n = 7'($urandom_range(36, 96));
        endcase
      end else if (pick < 62) begin
        k = KIND_NOTE_OFF;
        v = $urandom_range(0, VOICES - 1);
        if (pv_note[v] != 7'd0 && $urandom_range(0, 3) != 0) n = pv_note[v];
      end else begin
        k = KIND_TICK;
        // every word a live voice is about to read must hold data first
        for (int j = 0; j < VOICES; j++) begin
          a = pv_pos[j][31:16];
          if (pv_note[j] != 7'd0 && a < pv_len && !pv_written[a])
            send_item(KIND_LOAD, 7'($urandom), a, 16'($urandom));
        end
        a = 16'($urandom);
      end
      send_item(k, n, a, w);
    end
  endtask

  function automatic stim_row_t txn(input kind_e k, input int n, input int a, input int w,
                                    input bit f = 1'b0, input int e = 0);
    stim_row_t row;
    row.is_reg  = 1'b0;
    row.reg_sel = 1'b0;
    row.kind    = k;
    row.note    = n[6:0];
    row.addr    = a[15:0];
    row.data    = {2'b0, w[15:0]};
    row.fixed   = f;
    row.audio   = e[15:0];
    return row;
  endfunction

  function automatic stim_row_t reg_wr(input logic sel, input int d);
    stim_row_t row;
    row         = txn(KIND_LOAD, 0, 0, 0);
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.data    = d[17:0];
    return row;
  endfunction

  // receiving side
  initial begin : rx_side
    int idle_left;
    idle_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (idle_left == 0 && !quiet && $urandom_range(0, 5) == 0)
        idle_left = $urandom_range(1, 5);
      if (idle_left != 0) begin
        out_ready_i <= 1'b0;
        idle_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : audio_check
    logic signed [15:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (audio_expected_q.size() == 0) begin
        $display("%0t: audio_out %0d with no transaction pending", $time, audio_out_o);
        mismatch_cnt++;
      end else begin
        want = audio_expected_q.pop_front();
        if (audio_out_o !== want) begin
          $display("%0t: audio_out mismatch, expected %0d, got %0d", $time, want,
                   audio_out_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      pv_note[v] = '0;
      pv_pos[v]  = '0;
      pv_step[v] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back(txn(KIND_TICK, 0, 0, 0, 1'b1, 0));
    rows.push_back(txn(KIND_NOTE_ON, 60, 0, 0));
    // zero length: the voice reads nothing and parks at once
    rows.push_back(txn(KIND_TICK, 0, 0, 0, 1'b1, 0));
    rows.push_back(reg_wr(CFG_SAMPLE_LENGTH, 3));
    rows.push_back(txn(KIND_LOAD, 0, 0, -32768));
    rows.push_back(txn(KIND_LOAD, 0, 1, 32767));
    rows.push_back(txn(KIND_LOAD, 0, 2, 32767));
    rows.push_back(txn(KIND_TICK, 0, 0, 0));
    rows.push_back(txn(KIND_NOTE_OFF, 60, 0, 0));
    rows.push_back(txn(KIND_NOTE_OFF, 60, 0, 0));
    // note zero looks like a free slot
    rows.push_back(txn(KIND_NOTE_ON, 0, 0, 0));
    rows.push_back(txn(KIND_NOTE_OFF, 0, 0, 0));
    for (int n = 60; n < 75; n++) rows.push_back(txn(KIND_NOTE_ON, n, 0, 0));
    rows.push_back(txn(KIND_NOTE_ON, 127, 0, 0));
    rows.push_back(txn(KIND_NOTE_ON, 100, 0, 0));
    // sixteen voices on the lowest word, then fifteen on the highest; note 127 has run past the end
    rows.push_back(txn(KIND_TICK, 0, 0, 0, 1'b1, -32768));
    rows.push_back(txn(KIND_TICK, 0, 0, 0, 1'b1, 32767));

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        wait_drained(1'b1);
        write_reg(rows[i].reg_sel, rows[i].data);
      end else begin
        send_item(rows[i].kind, rows[i].note, rows[i].addr, rows[i].data[15:0],
                  rows[i].fixed, rows[i].audio);
      end
    end

    run_phase(16'd32, 18'd65536, 70, PRESS_NONE);
    run_phase(16'hFFFF, 18'h3FFFF, 70, PRESS_NONE);
    run_phase(16'd1, 18'd1, 60, PRESS_NONE);
    run_phase(16'd0, 18'd131072, 40, PRESS_NONE);
    run_phase(16'd200, 18'($urandom_range(1, 262143)), 90, PRESS_HOLD);
    run_phase(16'd64, 18'd98304, 80, PRESS_PAUSE);
    quiet = 1'b1;
    run_phase(16'd48, 18'($urandom_range(1, 262143)), 90, PRESS_NONE);

    wait_drained(1'b1);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
